// ===== rtl/core/date_serial_day_convert_defines.svh =====
// assertion macros used by the date serial converter rtl
`ifndef DATE_SERIAL_DAY_CONVERT_DEFINES_SVH
`define DATE_SERIAL_DAY_CONVERT_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked on every rising clock edge out of reset
`define DSDC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("dsdc assertion failed");
// condition in one cycle implies outcome in the next
`define DSDC_ASSERT_NEXT(lbl, clk, rstn, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error("dsdc assertion failed");
`else
`define DSDC_ASSERT(lbl, clk, rstn, prop)
`define DSDC_ASSERT_NEXT(lbl, clk, rstn, cond, nxt)
`endif
`endif

// ===== rtl/core/dsdc_pkg.sv =====
package dsdc_pkg;

    localparam int OP_W    = 2;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DELTA_W = 18;
    localparam int SER_W   = 17;
    localparam int TOT_W   = 19;
    localparam int YL_W    = 9;
    localparam int MONTHS  = 12;

    localparam logic [OP_W-1:0] OP_D2S = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD = 2'd1;
    localparam logic [OP_W-1:0] OP_S2D = 2'd2;

    localparam logic [DAY_W-1:0] MONTH_DAYS [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // year residues mod 4, 100 and 400, stepped along with the year
    typedef struct packed {
        logic [1:0] m4;
        logic [6:0] m100;
        logic [8:0] m400;
    } ymod_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic signed [DELTA_W-1:0] delta;
        logic [SER_W-1:0]          serial;
    } req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [SER_W-1:0]   serial;
        logic               err;
    } res_t;

    function automatic logic is_leap(input ymod_t m);
        return ((m.m4 == 2'd0) && (m.m100 != 7'd0)) || (m.m400 == 9'd0);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
                                                   input logic leap);
        logic [MONTH_W-1:0] k;
        k = ((idx >= 4'd1) && (idx <= 4'(MONTHS))) ? idx : 4'(MONTHS);
        return MONTH_DAYS[k] + ((k == 4'd2) ? 5'(leap) : 5'd0);
    endfunction

endpackage

// ===== rtl/core/dsdc_cal.sv =====
module dsdc_cal (
    input  dsdc_pkg::ymod_t                  cur,
    input  logic [dsdc_pkg::MONTH_W-1:0]     month_idx,
    output dsdc_pkg::ymod_t                  inc,
    output dsdc_pkg::ymod_t                  dec,
    output logic [dsdc_pkg::YL_W-1:0]        yl_cur,
    output logic [dsdc_pkg::YL_W-1:0]        yl_dec,
    output logic [dsdc_pkg::DAY_W-1:0]       ml
);

    logic leap_cur;
    logic leap_dec;

    always_comb begin
        inc.m4   = cur.m4 + 2'd1;
        inc.m100 = (cur.m100 == 7'd99)  ? 7'd0 : cur.m100 + 7'd1;
        inc.m400 = (cur.m400 == 9'd399) ? 9'd0 : cur.m400 + 9'd1;
        dec.m4   = cur.m4 - 2'd1;
        dec.m100 = (cur.m100 == 7'd0) ? 7'd99  : cur.m100 - 7'd1;
        dec.m400 = (cur.m400 == 9'd0) ? 9'd399 : cur.m400 - 9'd1;
    end

    assign leap_cur = dsdc_pkg::is_leap(cur);
    assign leap_dec = dsdc_pkg::is_leap(dec);
    assign yl_cur   = 9'd365 + 9'(leap_cur);
    assign yl_dec   = 9'd365 + 9'(leap_dec);
    assign ml       = dsdc_pkg::month_len(month_idx, leap_cur);

endmodule

// ===== rtl/core/dsdc_seq.sv =====
`include "date_serial_day_convert_defines.svh"

module dsdc_seq #(
    parameter int BASE_YEAR = 1900,
    parameter int YEAR_SPAN = 256
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  dsdc_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_ready,
    output dsdc_pkg::res_t  res
);

    localparam int YW_RAW = $clog2(BASE_YEAR + YEAR_SPAN + 1);
    localparam int YW     = (YW_RAW > dsdc_pkg::YEAR_W) ? YW_RAW : dsdc_pkg::YEAR_W;
    localparam int SOY_W  = $clog2(YEAR_SPAN * 366 + 1);
    localparam int TOT_W  = dsdc_pkg::TOT_W;
    localparam int SER_W  = dsdc_pkg::SER_W;

    localparam logic [YW-1:0] Y_LO = YW'(BASE_YEAR);
    localparam logic [YW-1:0] Y_HI = YW'(BASE_YEAR + YEAR_SPAN - 1);
    localparam dsdc_pkg::ymod_t MOD_INIT = '{
        m4:   2'(BASE_YEAR % 4),
        m100: 7'(BASE_YEAR % 100),
        m400: 9'(BASE_YEAR % 400)
    };
    localparam logic signed [TOT_W-1:0] TOT_ONE  = TOT_W'(1);
    localparam logic signed [TOT_W-1:0] TOT_YMAX = TOT_W'(366);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIY   = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_MONTH = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    dsdc_pkg::req_t                 req_reg, req_next;
    logic [YW-1:0]                  year_reg, year_next;
    dsdc_pkg::ymod_t                ymod_reg, ymod_next;
    logic [SOY_W-1:0]               soy_reg, soy_next;
    logic signed [TOT_W-1:0]        total_reg, total_next;
    logic [dsdc_pkg::MONTH_W-1:0]   idx_reg, idx_next;
    logic [SER_W-1:0]               ser_reg, ser_next;
    logic                           err_reg, err_next;

    dsdc_pkg::ymod_t                ymod_inc, ymod_dec;
    logic [dsdc_pkg::YL_W-1:0]      yl_cur, yl_dec;
    logic [dsdc_pkg::DAY_W-1:0]     ml;

    logic signed [TOT_W-1:0]        yl_cur_s, yl_dec_s, ml_s, delta_s;
    logic signed [TOT_W-1:0]        add_op, tot_sum;
    logic [SOY_W:0]                 ser_sum;
    logic [YW-1:0]                  yin_new, yin_reg;
    logic                           in_win, loop_diy, tot_low, tot_over, mon_over;

    dsdc_cal u_cal (
        .cur       (ymod_reg),
        .month_idx (idx_reg),
        .inc       (ymod_inc),
        .dec       (ymod_dec),
        .yl_cur    (yl_cur),
        .yl_dec    (yl_dec),
        .ml        (ml)
    );

    assign yl_cur_s = $signed({{(TOT_W-dsdc_pkg::YL_W){1'b0}}, yl_cur});
    assign yl_dec_s = $signed({{(TOT_W-dsdc_pkg::YL_W){1'b0}}, yl_dec});
    assign ml_s     = $signed({{(TOT_W-dsdc_pkg::DAY_W){1'b0}}, ml});
    assign delta_s  = $signed({{(TOT_W-dsdc_pkg::DELTA_W){req_reg.delta[dsdc_pkg::DELTA_W-1]}},
                               req_reg.delta});

    // the shared day adder: one operand chosen per cycle
    assign tot_sum = total_reg + add_op;
    assign ser_sum = (SOY_W+1)'(soy_reg) + (SOY_W+1)'(total_reg[8:0]);

    assign yin_new  = YW'(req.year);
    assign yin_reg  = YW'(req_reg.year);
    assign in_win   = (yin_new >= Y_LO) && (yin_new <= Y_HI);
    assign loop_diy = (idx_reg < req_reg.month) && (idx_reg <= 4'(dsdc_pkg::MONTHS));
    assign tot_low  = total_reg < TOT_ONE;
    assign tot_over = total_reg > yl_cur_s;
    assign mon_over = (idx_reg < 4'(dsdc_pkg::MONTHS)) && (total_reg > ml_s);

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        soy_next   = soy_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        ser_next   = ser_reg;
        err_next   = err_reg;
        add_op     = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next   = req;
                    year_next  = Y_LO;
                    ymod_next  = MOD_INIT;
                    soy_next   = '0;
                    idx_next   = 4'd1;
                    err_next   = 1'b0;
                    total_next = $signed(TOT_W'(req.day));
                    case (req.op) inside
                        dsdc_pkg::OP_D2S, dsdc_pkg::OP_ADD: begin
                            err_next   = !in_win;
                            state_next = in_win ? S_PREP : S_DONE;
                        end
                        dsdc_pkg::OP_S2D: begin
                            total_next = $signed(TOT_W'(req.serial));
                            state_next = S_WALK;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            // count whole years from the base up to the input year
            S_PREP: begin
                if (year_reg == yin_reg) begin
                    state_next = S_DIY;
                end else begin
                    soy_next  = soy_reg + SOY_W'(yl_cur);
                    year_next = year_reg + 1'b1;
                    ymod_next = ymod_inc;
                end
            end
            // day of year of the input date, one month a cycle; then add the delta or form the serial
            S_DIY: begin
                if (loop_diy) begin
                    add_op     = ml_s;
                    total_next = tot_sum;
                    idx_next   = idx_reg + 1'b1;
                end else if (req_reg.op == dsdc_pkg::OP_ADD) begin
                    add_op     = delta_s;
                    total_next = tot_sum;
                    idx_next   = 4'd1;
                    state_next = S_WALK;
                end else begin
                    ser_next   = (ser_sum == '0) ? SER_W'(1) : SER_W'(ser_sum);
                    state_next = S_DONE;
                end
            end
            S_WALK: begin
                if (tot_low) begin
                    if (year_reg == Y_LO) begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        add_op     = yl_dec_s;
                        total_next = tot_sum;
                        soy_next   = soy_reg - SOY_W'(yl_dec);
                        year_next  = year_reg - 1'b1;
                        ymod_next  = ymod_dec;
                    end
                end else if (tot_over) begin
                    if (year_reg == Y_HI) begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        add_op     = -yl_cur_s;
                        total_next = tot_sum;
                        soy_next   = soy_reg + SOY_W'(yl_cur);
                        year_next  = year_reg + 1'b1;
                        ymod_next  = ymod_inc;
                    end
                end else begin
                    // total is now the day of year of the result
                    ser_next   = SER_W'(ser_sum);
                    idx_next   = 4'd1;
                    state_next = S_MONTH;
                end
            end
            S_MONTH: begin
                if (mon_over) begin
                    add_op     = -ml_s;
                    total_next = tot_sum;
                    idx_next   = idx_reg + 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        res = '0;
        if (err_reg) begin
            res.year  = req_reg.year;
            res.month = req_reg.month;
            res.day   = req_reg.day;
            res.err   = 1'b1;
        end else begin
            unique case (req_reg.op)
                dsdc_pkg::OP_D2S: begin
                    res.year   = req_reg.year;
                    res.month  = req_reg.month;
                    res.day    = req_reg.day;
                    res.serial = ser_reg;
                end
                dsdc_pkg::OP_ADD: begin
                    res.year   = year_reg[dsdc_pkg::YEAR_W-1:0];
                    res.month  = idx_reg;
                    res.day    = total_reg[dsdc_pkg::DAY_W-1:0];
                    res.serial = ser_reg;
                end
                dsdc_pkg::OP_S2D: begin
                    res.year   = year_reg[dsdc_pkg::YEAR_W-1:0];
                    res.month  = idx_reg;
                    res.day    = total_reg[dsdc_pkg::DAY_W-1:0];
                    res.serial = req_reg.serial;
                end
                default: res = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        year_reg  <= year_next;
        ymod_reg  <= ymod_next;
        soy_reg   <= soy_next;
        total_reg <= total_next;
        idx_reg   <= idx_next;
        ser_reg   <= ser_next;
        err_reg   <= err_next;
    end

    `DSDC_ASSERT(a_year_in_window, aclk, aresetn, (state_reg != S_IDLE) |-> ((year_reg >= Y_LO) && (year_reg <= Y_HI)))
    `DSDC_ASSERT(a_mod4_tracks_year, aclk, aresetn, (state_reg != S_IDLE) |-> (ymod_reg.m4 == year_reg[1:0]))
    `DSDC_ASSERT(a_month_walk_day, aclk, aresetn, (state_reg == S_MONTH) |-> ((total_reg >= TOT_ONE) && (total_reg <= TOT_YMAX) && (idx_reg >= 4'd1) && (idx_reg <= 4'(dsdc_pkg::MONTHS))))
    `DSDC_ASSERT(a_prep_below_input, aclk, aresetn, (state_reg == S_PREP) |-> (year_reg <= yin_reg))
    `DSDC_ASSERT_NEXT(a_done_holds, aclk, aresetn, (state_reg == S_DONE) && !res_ready, state_reg == S_DONE)

endmodule

// ===== rtl/core/date_serial_day_convert.sv =====
// the sequencer steps Y years (up to in_year - BASE_YEAR, then up to YEAR_SPAN - 1 more)
// and M months (up to 23) between accept and result
// throughput: one item per conversion, the next accepted in the cycle after the result leaves
// the sequencer; the year and month walk through the shared day adder, one step a cycle,
// sets how long a conversion takes
// reset: synchronous active-low aresetn clears the sequencer and the output valid
module date_serial_day_convert #(
    parameter int BASE_YEAR = 1900,
    parameter int YEAR_SPAN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // in_year[11:0], in_month[15:12], in_day[20:16], day_delta[38:21], serial_in[55:39]
    input  logic [55:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_year[11:0], res_month[15:12], res_day[20:16], serial_out[37:21], zero[39:38]
    output logic [39:0] m_axis_tdata,
    // range_error[0]
    output logic        m_axis_tuser
);

    dsdc_pkg::req_t req;
    dsdc_pkg::res_t res;
    dsdc_pkg::res_t m_res_reg;
    logic           m_valid_reg;
    logic           res_valid;
    logic           res_ready;

    assign req.op     = s_axis_tuser;
    assign req.year   = s_axis_tdata[11:0];
    assign req.month  = s_axis_tdata[15:12];
    assign req.day    = s_axis_tdata[20:16];
    assign req.delta  = s_axis_tdata[38:21];
    assign req.serial = s_axis_tdata[55:39];

    dsdc_seq #(
        .BASE_YEAR (BASE_YEAR),
        .YEAR_SPAN (YEAR_SPAN)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output slot frees the sequencer as soon as it is empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_res_reg.serial, m_res_reg.day,
                            m_res_reg.month, m_res_reg.year};
    assign m_axis_tuser  = m_res_reg.err;

endmodule
